### sv/q4k_pkg.sv
// ---------------------------------------------------------------------------
// q4k_pkg
// Shared types and constants for the k-quant block dot product.
// ---------------------------------------------------------------------------
package q4k_pkg;

  localparam int BEATS = 16;
  localparam int SDOT_W = 27;
  localparam int MTERM_W = 24;

  // One closed superblock, handed from the front to the float back end.
  typedef struct packed {
    logic signed [SDOT_W-1:0]  sdot;
    logic signed [MTERM_W-1:0] mterm;
    logic [15:0]               wscale;
    logic [15:0]               wmin;
    logic [31:0]               ascale;
    logic                      last;
  } q4k_rec_t;

  // Scales and mins of one pair of subblocks.
  typedef struct packed {
    logic [5:0] sc_lo;
    logic [5:0] sc_hi;
    logic [5:0] mn_lo;
    logic [5:0] mn_hi;
  } q4k_pair_t;

  localparam logic [31:0] CANON_NAN = 32'h7fc0_0000;

endpackage

### sv/q4k_fifo.sv
// ---------------------------------------------------------------------------
// q4k_fifo
// Short queue of closed superblocks between front and back.
// ---------------------------------------------------------------------------
module q4k_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  q4k_pkg::q4k_rec_t wdata,
  input  logic              rd,
  output q4k_pkg::q4k_rec_t rdata,
  output logic              empty,
  output logic              afull
);
  import q4k_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q4k_rec_t        mem [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;

  assign rdata = mem[rptr];
  assign empty = (count == '0);
  assign afull = (count >= CW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/q4k_front.sv
// ---------------------------------------------------------------------------
// q4k_front
// Accept beats, unpack scales, form integer sums, close superblocks.
// ---------------------------------------------------------------------------
module q4k_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [15:0]       weight_scale_half,
  input  logic [15:0]       weight_min_half,
  input  logic [63:0]       packed_scales_lo,
  input  logic [31:0]       packed_scales_hi,
  input  logic [31:0]       act_scale_bits,
  input  logic [63:0]       weight_nibble_bytes,
  input  logic [63:0]       act_bytes_low,
  input  logic [63:0]       act_bytes_high,
  input  logic              row_end,
  output logic              rec_push,
  output q4k_pkg::q4k_rec_t rec
);
  import q4k_pkg::*;

  logic [3:0]       beat_index;
  q4k_pair_t        pairs [4];
  logic [15:0]      held_wscale;
  logic [15:0]      held_wmin;
  logic [31:0]      held_ascale;
  logic signed [SDOT_W-1:0]  sdot;
  logic signed [MTERM_W-1:0] mterm;

  logic [7:0]       q [12];
  q4k_pair_t        unpacked [4];
  q4k_pair_t        sel;
  logic             first;
  logic signed [15:0] dlo;
  logic signed [15:0] dhi;
  logic signed [11:0] slo;
  logic signed [11:0] shi;
  logic             closing;

  // stage one
  logic             s1_valid;
  logic             s1_close;
  logic             s1_last;
  q4k_pair_t        s1_pair;
  logic signed [15:0] s1_dlo;
  logic signed [15:0] s1_dhi;
  logic signed [11:0] s1_slo;
  logic signed [11:0] s1_shi;

  logic signed [SDOT_W-1:0]  sdot_next;
  logic signed [MTERM_W-1:0] mterm_next;

  assign first   = (beat_index == '0);
  assign closing = (beat_index == 4'(BEATS - 1)) || row_end;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      q[k] = packed_scales_lo[8*k +: 8];
    end
    for (int k = 0; k < 4; k++) begin
      q[8+k] = packed_scales_hi[8*k +: 8];
    end
    for (int k = 0; k < 4; k++) begin
      // subblock k and k+4 belong to pairs k/2 and k/2+2
      if (k[0] == 1'b0) begin
        unpacked[k/2].sc_lo = q[k][5:0];
        unpacked[k/2].mn_lo = q[k+4][5:0];
        unpacked[k/2+2].sc_lo = {q[k][7:6], q[k+8][3:0]};
        unpacked[k/2+2].mn_lo = {q[k+4][7:6], q[k+8][7:4]};
      end else begin
        unpacked[k/2].sc_hi = q[k][5:0];
        unpacked[k/2].mn_hi = q[k+4][5:0];
        unpacked[k/2+2].sc_hi = {q[k][7:6], q[k+8][3:0]};
        unpacked[k/2+2].mn_hi = {q[k+4][7:6], q[k+8][7:4]};
      end
    end
  end

  assign sel = first ? unpacked[beat_index[3:2]] : pairs[beat_index[3:2]];

  always_comb begin
    dlo = '0;
    dhi = '0;
    slo = '0;
    shi = '0;
    for (int k = 0; k < 8; k++) begin
      dlo = dlo + 16'($signed({1'b0, weight_nibble_bytes[8*k +: 4]})
                      * $signed(act_bytes_low[8*k +: 8]));
      dhi = dhi + 16'($signed({1'b0, weight_nibble_bytes[8*k+4 +: 4]})
                      * $signed(act_bytes_high[8*k +: 8]));
      slo = slo + 12'($signed(act_bytes_low[8*k +: 8]));
      shi = shi + 12'($signed(act_bytes_high[8*k +: 8]));
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (first) begin
        pairs       <= unpacked;
        held_wscale <= weight_scale_half;
        held_wmin   <= weight_min_half;
        held_ascale <= act_scale_bits;
      end
      s1_pair  <= sel;
      s1_dlo   <= dlo;
      s1_dhi   <= dhi;
      s1_slo   <= slo;
      s1_shi   <= shi;
      s1_close <= closing;
      s1_last  <= row_end;
    end
  end

  assign sdot_next = sdot
    + SDOT_W'(s1_dlo * $signed({1'b0, s1_pair.sc_lo}))
    + SDOT_W'(s1_dhi * $signed({1'b0, s1_pair.sc_hi}));
  assign mterm_next = mterm
    + MTERM_W'(s1_slo * $signed({1'b0, s1_pair.mn_lo}))
    + MTERM_W'(s1_shi * $signed({1'b0, s1_pair.mn_hi}));

  assign rec_push     = s1_valid && s1_close;
  assign rec.sdot     = sdot_next;
  assign rec.mterm    = mterm_next;
  assign rec.wscale   = held_wscale;
  assign rec.wmin     = held_wmin;
  assign rec.ascale   = held_ascale;
  assign rec.last     = s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_index <= '0;
      s1_valid   <= 1'b0;
      sdot       <= '0;
      mterm      <= '0;
    end else begin
      s1_valid <= take;
      if (take) begin
        beat_index <= closing ? '0 : beat_index + 1'b1;
      end
      if (s1_valid) begin
        // drop the sums once the superblock is queued
        sdot  <= s1_close ? '0 : sdot_next;
        mterm <= s1_close ? '0 : mterm_next;
      end
    end
  end

endmodule

### sv/q4k_back.sv
// ---------------------------------------------------------------------------
// q4k_back
// Float fixup sequencer: one shared multiply/add/convert unit, each operation
// passing through operate, leading-one and round phases, eight operations a superblock.
// ---------------------------------------------------------------------------
module q4k_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  q4k_pkg::q4k_rec_t q_data,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [31:0]       row_dot_bits
);
  import q4k_pkg::*;

  localparam logic [1:0] PH_OPER  = 2'd0;
  localparam logic [1:0] PH_LEAD  = 2'd1;
  localparam logic [1:0] PH_ROUND = 2'd2;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;
  localparam logic [1:0] OP_CVT = 2'd3;

  localparam logic [2:0] LAST_STEP = 3'd7;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  lead;
    logic [9:0]  sm;
    logic [31:0] r;
    e = h[14:10];
    m = h[9:0];
    lead = '0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        lead = 4'(i);
      end
    end
    sm = m << (4'd10 - lead);
    if (e == 5'd31) begin
      r = {h[15], 8'hff, m, 13'd0} | ((m != '0) ? 32'h0040_0000 : 32'd0);
    end else if (e == '0) begin
      if (m == '0) begin
        r = {h[15], 31'd0};
      end else begin
        r = {h[15], 8'(8'd103 + 8'(lead)), sm, 13'd0};
      end
    end else begin
      r = {h[15], 8'(8'(e) + 8'd112), m, 13'd0};
    end
    return r;
  endfunction

  logic        busy;
  logic [2:0]  step;
  logic [1:0]  phase;
  q4k_rec_t    cur;
  logic [31:0] wd, wdm, wfm, wfs, wp, acc;
  logic        out_valid;

  // operation decode
  logic [1:0]  op;
  logic [31:0] fa, fb;
  logic signed [SDOT_W-1:0] iv;

  always_comb begin
    op = OP_MUL;
    fa = acc;
    fb = wp;
    iv = '0;
    unique case (step)
      3'd0: begin fa = cur.ascale; fb = half_to_single(cur.wscale); end
      3'd1: begin fa = cur.ascale; fb = half_to_single(cur.wmin); end
      3'd2: begin op = OP_CVT; iv = SDOT_W'(cur.mterm); end
      3'd3: begin op = OP_CVT; iv = cur.sdot; end
      3'd4: begin fa = wdm; fb = wfm; end
      3'd5: begin op = OP_SUB; end
      3'd6: begin fa = wd; fb = wfs; end
      3'd7: begin op = OP_ADD; end
      default: begin end
    endcase
  end

  // unpack operands
  logic [23:0]        ma, mb;
  logic signed [11:0] ea, eb;
  logic               na, nb, ia, ib, za, zb, sa, sb;

  always_comb begin
    ma = {fa[30:23] != '0, fa[22:0]};
    mb = {fb[30:23] != '0, fb[22:0]};
    ea = (fa[30:23] == '0) ? 12'sd1 : $signed({4'd0, fa[30:23]});
    eb = (fb[30:23] == '0) ? 12'sd1 : $signed({4'd0, fb[30:23]});
    na = (fa[30:23] == 8'hff) && (fa[22:0] != '0);
    nb = (fb[30:23] == 8'hff) && (fb[22:0] != '0);
    ia = (fa[30:23] == 8'hff) && (fa[22:0] == '0);
    ib = (fb[30:23] == 8'hff) && (fb[22:0] == '0);
    za = (fa[30:0] == '0);
    zb = (fb[30:0] == '0);
    sa = fa[31];
    sb = fb[31] ^ (op == OP_SUB);
  end

  // operation phase: exact significand, exponent, sign and special cases
  logic [49:0]        m_c;
  logic signed [11:0] e_c;
  logic               s_c, nan_c, inf_c;
  logic               big_a, eff_sub;
  logic [23:0]        m_big, m_small;
  logic signed [11:0] e_big, e_diff;
  logic [49:0]        sm_full, sm_shift;
  logic               sm_lost;
  logic [SDOT_W-1:0]  mag;

  always_comb begin
    big_a    = (ea > eb) || ((ea == eb) && (ma >= mb));
    m_big    = big_a ? ma : mb;
    m_small  = big_a ? mb : ma;
    e_big    = big_a ? ea : eb;
    e_diff   = big_a ? (ea - eb) : (eb - ea);
    eff_sub  = (sa != sb);
    sm_full  = {2'd0, m_small, 24'd0};
    sm_shift = sm_full >> e_diff[7:0];
    sm_lost  = ((sm_shift << e_diff[7:0]) != sm_full);
    mag      = iv[SDOT_W-1] ? SDOT_W'(-iv) : SDOT_W'(iv);
    m_c   = '0;
    e_c   = '0;
    s_c   = 1'b0;
    nan_c = 1'b0;
    inf_c = 1'b0;
    unique case (op)
      OP_MUL: begin
        m_c   = {1'b0, 48'(ma * mb), 1'b0};
        e_c   = ea + eb - 12'sd127;
        s_c   = sa ^ sb;
        nan_c = na || nb || (ia && zb) || (za && ib);
        inf_c = ia || ib;
      end
      OP_ADD, OP_SUB: begin
        m_c = eff_sub ? ({2'd0, m_big, 24'd0} - (sm_shift | 50'(sm_lost)))
                      : ({2'd0, m_big, 24'd0} + (sm_shift | 50'(sm_lost)));
        e_c = e_big;
        if (m_c == '0) begin
          s_c = eff_sub ? 1'b0 : sa;
        end else begin
          s_c = big_a ? sa : sb;
        end
        nan_c = na || nb || (ia && ib && eff_sub);
        inf_c = ia || ib;
        if (ia || ib) begin
          s_c = ia ? sa : sb;
        end
      end
      OP_CVT: begin
        m_c = 50'(mag);
        e_c = 12'sd174;
        s_c = iv[SDOT_W-1];
      end
      default: begin end
    endcase
  end

  logic [49:0]        m_r;
  logic signed [11:0] e_r;
  logic               s_r, nan_r, inf_r;
  logic [5:0]         p_r;
  logic [5:0]         p_c;

  // leading one search
  always_comb begin
    p_c = '0;
    for (int i = 0; i < 50; i++) begin
      if (m_r[i]) begin
        p_c = 6'(i);
      end
    end
  end

  // round and pack
  logic signed [11:0] e_norm, e_fin, sh;
  logic [5:0]         shr;
  logic [49:0]        rm;
  logic               lost, g, st, inc;
  logic [24:0]        m25;
  logic [11:0]        ef;
  logic [31:0]        res;

  always_comb begin
    e_norm = e_r + $signed({6'd0, p_r}) - 12'sd47;
    e_fin  = (e_norm < 12'sd1) ? 12'sd1 : e_norm;
    sh     = e_fin - e_r;
    shr    = (sh > 12'sd63) ? 6'd63 : sh[5:0];
    if (sh >= 12'sd0) begin
      rm   = m_r >> shr;
      lost = ((rm << shr) != m_r);
    end else begin
      rm   = m_r << 6'(-sh);
      lost = 1'b0;
    end
    g   = rm[23];
    st  = (rm[22:0] != '0) || lost;
    inc = g && (st || rm[24]);
    m25 = {1'b0, rm[47:24]} + 25'(inc);
    if (m25[24]) begin
      ef = 12'(e_fin + 12'sd1);
    end else if (m25[23]) begin
      ef = 12'(e_fin);
    end else begin
      ef = '0;
    end
    if (nan_r) begin
      res = CANON_NAN;
    end else if (inf_r || (m_r != '0 && ef >= 12'd255)) begin
      res = {s_r, 8'hff, 23'd0};
    end else if (m_r == '0) begin
      res = {s_r, 31'd0};
    end else begin
      res = {s_r, ef[7:0], m25[22:0]};
    end
  end

  assign q_pop        = !busy && !q_empty && !out_valid;
  assign empty        = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (busy && phase == PH_OPER) begin
      m_r   <= m_c;
      e_r   <= e_c;
      s_r   <= s_c;
      nan_r <= nan_c;
      inf_r <= inf_c;
    end
    if (busy && phase == PH_LEAD) begin
      p_r <= p_c;
    end
    if (busy && phase == PH_ROUND) begin
      unique case (step)
        3'd0: wd <= res;
        3'd1: wdm <= res;
        3'd2: wfm <= res;
        3'd3: wfs <= res;
        3'd4, 3'd6: wp <= res;
        default: begin end
      endcase
      if (step == LAST_STEP && cur.last) begin
        // hand out the row, canonical NaN already applied in packing
        row_dot_bits <= res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      phase     <= PH_OPER;
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy  <= 1'b1;
        step  <= '0;
        phase <= PH_OPER;
      end else if (busy) begin
        unique case (phase)
          PH_OPER:  phase <= PH_LEAD;
          PH_LEAD:  phase <= PH_ROUND;
          PH_ROUND: begin
            phase <= PH_OPER;
            if (step == 3'd5) begin
              acc <= res;
            end
            if (step == LAST_STEP) begin
              busy <= 1'b0;
              if (cur.last) begin
                out_valid <= 1'b1;
                acc       <= '0;
              end else begin
                acc <= res;
              end
            end else begin
              step <= step + 1'b1;
            end
          end
          default: phase <= PH_OPER;
        endcase
      end
    end
  end

endmodule

### sv/q4k_block_dot_product_top.sv
// ---------------------------------------------------------------------------
// q4k_block_dot_product_top
// Streams a row of 4-bit k-quant weights against int8 activations and
// returns the row dot product as an IEEE single.
// ---------------------------------------------------------------------------
// Path: with the back end idle, a row result follows its last accepted word
//   through the front stage, queue write and pop, then the eight operations.
// Throughput: the front takes one word a cycle while full is low; the float
//   back end pops a superblock only when idle and runs its eight operations
//   one at a time through one shared unit before taking the next superblock;
//   a waiting row result holds the back end until popped.
// Reset (rst, synchronous): clears beat count, sums, queue and accumulator.
// ---------------------------------------------------------------------------
module q4k_block_dot_product_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] weight_scale_half,
  input  logic [15:0] weight_min_half,
  input  logic [63:0] packed_scales_lo,
  input  logic [31:0] packed_scales_hi,
  input  logic [31:0] act_scale_bits,
  input  logic [63:0] weight_nibble_bytes,
  input  logic [63:0] act_bytes_low,
  input  logic [63:0] act_bytes_high,
  input  logic        row_end,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] row_dot_bits
);
  import q4k_pkg::*;

  logic     take;
  logic     rec_push;
  q4k_rec_t rec;
  q4k_rec_t q_data;
  logic     q_empty;
  logic     q_afull;
  logic     q_pop;

  // Hold off new words while the queue could not absorb a superblock that
  // is still in flight in the front pipeline.
  assign full = q_afull;
  assign take = push && !full;

  // Front: unpack scales on the first word, form the integer sums, close
  // a superblock after sixteen words or at the row end.
  q4k_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .take                (take),
    .weight_scale_half   (weight_scale_half),
    .weight_min_half     (weight_min_half),
    .packed_scales_lo    (packed_scales_lo),
    .packed_scales_hi    (packed_scales_hi),
    .act_scale_bits      (act_scale_bits),
    .weight_nibble_bytes (weight_nibble_bytes),
    .act_bytes_low       (act_bytes_low),
    .act_bytes_high      (act_bytes_high),
    .row_end             (row_end),
    .rec_push            (rec_push),
    .rec                 (rec)
  );

  // Queue of closed superblocks; lets front and back stall separately.
  q4k_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (rec_push),
    .wdata (rec),
    .rd    (q_pop),
    .rdata (q_data),
    .empty (q_empty),
    .afull (q_afull)
  );

  // Back: apply the float fixup per superblock, emit the row on its end.
  q4k_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .row_dot_bits (row_dot_bits)
  );

endmodule
